[hdl/segsum_pkg.sv]
// ============================================================================
// segsum_pkg: shared types and constants for the segment tree range-sum block
// Transaction structs, field widths, opcodes and shared-adder operations.
// ============================================================================
package segsum_pkg;

  // Field widths
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 10;
  localparam int unsigned CNT_W = 11;

  // Default number of positions the stores are sized for
  localparam int unsigned DEF_MAX_ELEMENTS = 1024;

  // Opcodes
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sum returned for a rejected query
  localparam logic signed [VAL_W-1:0] SUM_INVALID = -32'sd1;

  // Shared adder operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Input transaction
  typedef struct packed {
    logic                    opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
    logic [POS_W-1:0]        range_low;
    logic [POS_W-1:0]        range_high;
  } segsum_req_t;

  // Result transaction
  typedef struct packed {
    logic signed [VAL_W-1:0] range_sum;
    logic                    bad_request;
  } segsum_rsp_t;

endpackage

[hdl/segsum_ram.sv]
// ============================================================================
// segsum_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module segsum_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/segsum_alu.sv]
// ============================================================================
// segsum_alu: shared 32-bit adder
// Wrapping add or subtract used for difference, node update and accumulation.
// ============================================================================
module segsum_alu
  import segsum_pkg::*;
(
  input  alu_op_e          op_i,
  input  logic [VAL_W-1:0] a_i,
  input  logic [VAL_W-1:0] b_i,
  output logic [VAL_W-1:0] y_o
);

  // Select add or subtract, result wraps modulo 2^32
  always_comb begin
    case (op_i)
      ALU_ADD: y_o = a_i + b_i;
      ALU_SUB: y_o = a_i - b_i;
      default: y_o = a_i + b_i;
    endcase
  end

endmodule

[hdl/segment_tree_range_sum_top.sv]
// ============================================================================
// segment_tree_range_sum_top: segment tree range sum with point update
// Node sums and leaf values in RAM, walked by a sequencer with one adder.
// ============================================================================
// Holds element_count signed 32-bit values and a tree of partial sums in a
// 4*MAX_ELEMENTS node RAM plus a MAX_ELEMENTS leaf RAM. One transaction is
// worked at a time; in_stall_o stays high until its result is loaded into the
// output register. A set reads the old leaf, forms the difference, then at
// each tree level (11 levels at 1024 positions) reads a node and writes it
// back plus the difference through the shared adder. A query visits at most
// four nodes per level and adds each covered node into its sum through the
// same adder. Rejected requests skip the tree walk.
// After reset and after every element_count write both RAMs are
// cleared, one entry per cycle, over all 4*MAX_ELEMENTS node addresses,
// during which no transaction is accepted. Counts above MAX_ELEMENTS
// saturate.
module segment_tree_range_sum_top
  import segsum_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  segsum_req_t      in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output segsum_rsp_t      out_data_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i
);

  localparam int unsigned NODE_DEPTH  = 4 * MAX_ELEMENTS;
  localparam int unsigned NODE_AW     = $clog2(NODE_DEPTH);
  localparam int unsigned LEAF_AW     = $clog2(MAX_ELEMENTS);
  localparam int unsigned STACK_DEPTH = $clog2(MAX_ELEMENTS) + 1;
  localparam int unsigned SP_IDX_W    = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);

  typedef logic [CNT_W-1:0] span_t;

  typedef struct packed {
    logic [NODE_AW-1:0] node;
    span_t              lo;
    span_t              hi;
  } frame_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ULEAF,
    ST_UDIFF,
    ST_URD,
    ST_UWR,
    ST_QVISIT,
    ST_QDRAIN,
    ST_FINISH
  } state_e;

  // Control registers
  state_e             state_q, state_d;
  span_t              cnt_q, cnt_d;
  logic [NODE_AW-1:0] clr_q, clr_d;
  logic [SP_W-1:0]    sp_q, sp_d;
  logic               pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  segsum_rsp_t        out_data_q, out_data_d;

  // Datapath registers
  segsum_req_t        item_q, item_d;
  logic [NODE_AW-1:0] node_q, node_d;
  span_t              lo_q, lo_d;
  span_t              hi_q, hi_d;
  logic [VAL_W-1:0]   diff_q, diff_d;
  logic [VAL_W-1:0]   acc_q, acc_d;
  segsum_rsp_t        res_q, res_d;
  frame_t             stack_q [STACK_DEPTH];

  // RAM and adder hookup
  logic               node_we, node_re, leaf_we, leaf_re;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  logic [LEAF_AW-1:0] leaf_waddr, leaf_raddr;
  logic [VAL_W-1:0]   node_wdata, leaf_wdata, node_rdata, leaf_rdata;
  alu_op_e            alu_op;
  logic [VAL_W-1:0]   alu_a, alu_b, alu_y;

  // Tree walk helpers
  span_t              mid, qlo, qhi, pos_ext;
  logic [NODE_AW-1:0] child_l, child_r;
  logic               covered, disjoint, push;
  frame_t             push_frame, top_frame;
  logic [SP_W-1:0]    sp_m1;
  span_t              cnt_sat;

  segsum_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NODE_DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (node_we),
    .waddr_i(node_waddr),
    .wdata_i(node_wdata),
    .re_i   (node_re),
    .raddr_i(node_raddr),
    .rdata_o(node_rdata)
  );

  segsum_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_leaf_ram (
    .clk_i  (clk_i),
    .we_i   (leaf_we),
    .waddr_i(leaf_waddr),
    .wdata_i(leaf_wdata),
    .re_i   (leaf_re),
    .raddr_i(leaf_raddr),
    .rdata_o(leaf_rdata)
  );

  segsum_alu u_alu (
    .op_i(alu_op),
    .a_i (alu_a),
    .b_i (alu_b),
    .y_o (alu_y)
  );

  // Split the current span and classify it against the query range
  always_comb begin
    mid      = lo_q + ((hi_q - lo_q) >> 1);
    child_l  = NODE_AW'({node_q, 1'b0} + (NODE_AW + 1)'(1));
    child_r  = NODE_AW'({node_q, 1'b0} + (NODE_AW + 1)'(2));
    qlo      = CNT_W'(item_q.range_low);
    qhi      = CNT_W'(item_q.range_high);
    pos_ext  = CNT_W'(item_q.position);
    covered  = (qlo <= lo_q) && (qhi >= hi_q);
    disjoint = (hi_q < qlo) || (qhi < lo_q);
    sp_m1    = sp_q - SP_W'(1);
    top_frame  = stack_q[sp_m1[SP_IDX_W-1:0]];
    push_frame = '{node: child_r, lo: mid + CNT_W'(1), hi: hi_q};
    if (32'(cfg_data_i) > 32'(MAX_ELEMENTS)) begin
      cnt_sat = CNT_W'(MAX_ELEMENTS);
    end else begin
      cnt_sat = cfg_data_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    sp_d        = sp_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    item_d      = item_q;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    diff_d      = diff_q;
    acc_d       = acc_q;
    res_d       = res_q;
    push        = 1'b0;

    node_we    = 1'b0;
    node_re    = 1'b0;
    node_waddr = node_q;
    node_raddr = node_q;
    node_wdata = alu_y;
    leaf_we    = 1'b0;
    leaf_re    = 1'b0;
    leaf_waddr = LEAF_AW'(item_q.position);
    leaf_raddr = LEAF_AW'(item_q.position);
    leaf_wdata = item_q.new_value;

    // Shared adder defaults to accumulating the query sum
    alu_op = ALU_ADD;
    alu_a  = acc_q;
    alu_b  = node_rdata;

    // Fold in the node read issued last cycle
    if (pend_q) begin
      acc_d = alu_y;
    end

    // Drop the output once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wdata = '0;
        leaf_we    = clr_q < NODE_AW'(MAX_ELEMENTS);
        leaf_waddr = LEAF_AW'(clr_q);
        leaf_wdata = '0;
        if (clr_q == NODE_AW'(NODE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + NODE_AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          if (in_data_i.opcode == OP_SET) begin
            if (CNT_W'(in_data_i.position) >= cnt_q) begin
              res_d   = '{range_sum: '0, bad_request: 1'b1};
              state_d = ST_FINISH;
            end else begin
              state_d = ST_ULEAF;
            end
          end else begin
            if ((cnt_q == '0) || (in_data_i.range_low > in_data_i.range_high) ||
                (CNT_W'(in_data_i.range_high) >= cnt_q)) begin
              res_d   = '{range_sum: SUM_INVALID, bad_request: 1'b1};
              state_d = ST_FINISH;
            end else begin
              node_d  = '0;
              lo_d    = '0;
              hi_d    = cnt_q - CNT_W'(1);
              sp_d    = '0;
              acc_d   = '0;
              state_d = ST_QVISIT;
            end
          end
        end
      end
      ST_ULEAF: begin
        leaf_re = 1'b1;
        state_d = ST_UDIFF;
      end
      ST_UDIFF: begin
        alu_op  = ALU_SUB;
        alu_a   = item_q.new_value;
        alu_b   = leaf_rdata;
        diff_d  = alu_y;
        leaf_we = 1'b1;
        node_d  = '0;
        lo_d    = '0;
        hi_d    = cnt_q - CNT_W'(1);
        state_d = ST_URD;
      end
      ST_URD: begin
        node_re = 1'b1;
        state_d = ST_UWR;
      end
      ST_UWR: begin
        // Write back node sum plus difference, then descend toward the leaf
        alu_op  = ALU_ADD;
        alu_a   = node_rdata;
        alu_b   = diff_q;
        node_we = 1'b1;
        if (lo_q == hi_q) begin
          res_d   = '{range_sum: '0, bad_request: 1'b0};
          state_d = ST_FINISH;
        end else if (pos_ext <= mid) begin
          node_d  = child_l;
          hi_d    = mid;
          state_d = ST_URD;
        end else begin
          node_d  = child_r;
          lo_d    = mid + CNT_W'(1);
          state_d = ST_URD;
        end
      end
      ST_QVISIT: begin
        if (covered || disjoint) begin
          // Read a covered node, then pop the next span or wrap up
          node_re = covered;
          pend_d  = covered;
          if (sp_q != '0) begin
            node_d = top_frame.node;
            lo_d   = top_frame.lo;
            hi_d   = top_frame.hi;
            sp_d   = sp_m1;
          end else begin
            state_d = ST_QDRAIN;
          end
        end else begin
          // Save the upper half, descend into the lower half
          push   = 1'b1;
          sp_d   = sp_q + SP_W'(1);
          node_d = child_l;
          hi_d   = mid;
        end
      end
      ST_QDRAIN: begin
        res_d   = '{range_sum: (pend_q ? alu_y : acc_q), bad_request: 1'b0};
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A count write relayouts the tree: restart the clearing sweep
    if (cfg_we_i) begin
      cnt_d   = cnt_sat;
      clr_d   = '0;
      state_d = ST_CLEAR;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= CNT_W'(MAX_ELEMENTS);
      clr_q       <= '0;
      sp_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    node_q <= node_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    diff_q <= diff_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    if (push) begin
      stack_q[sp_q[SP_IDX_W-1:0]] <= push_frame;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Span stack never overflows on a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (32'(sp_q) < 32'(STACK_DEPTH)))
    else $error("span stack overflow");

  // Update walk always holds a non-empty span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UWR || state_q == ST_URD) |-> (lo_q <= hi_q))
    else $error("update walk span inverted");

  // A pending node read only follows a query visit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == ST_QVISIT))
    else $error("accumulate without a query read");

  // An accepted transaction leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted transaction not started");

endmodule

[dv/tb_top.sv]
// ============================================================================
// tb_top: testbench for the segment tree range-sum block
// Drives set and query transactions, predicts each result from a
// flat copy of the stored values, and checks every result in order.
// ============================================================================
module tb_top;
  import segsum_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_POSITIONS = DEF_MAX_ELEMENTS;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS   = 92;

  logic             clk;
  logic             rst_n;
  logic             in_valid_i;
  logic             in_stall_o;
  segsum_req_t      in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  segsum_rsp_t      out_data_o;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_data_i;

  // Shadow of the block's state
  int unsigned       position_count;
  logic [VAL_W-1:0]  value_store [NUM_POSITIONS];

  segsum_rsp_t       pending_sums[$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;

  segment_tree_range_sum_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Compute the result of one request and update the shadow values
  function automatic segsum_rsp_t apply_request(segsum_req_t req);
    segsum_rsp_t      rsp;
    logic [VAL_W-1:0] acc;
    rsp.range_sum   = '0;
    rsp.bad_request = 1'b0;
    if (req.opcode == OP_SET) begin
      if (req.position >= position_count) begin
        rsp.bad_request = 1'b1;
      end else begin
        value_store[req.position] = req.new_value;
      end
    end else if (position_count == 0 || req.range_low > req.range_high ||
                 req.range_high >= position_count) begin
      rsp.range_sum   = SUM_INVALID;
      rsp.bad_request = 1'b1;
    end else begin
      acc = '0;
      for (int p = req.range_low; p <= req.range_high; p++) begin
        acc += value_store[p];
      end
      rsp.range_sum = acc;
    end
    return rsp;
  endfunction

  function automatic segsum_req_t make_set(int unsigned pos, logic [VAL_W-1:0] val);
    segsum_req_t req;
    req.opcode     = OP_SET;
    req.position   = pos[POS_W-1:0];
    req.new_value  = val;
    req.range_low  = POS_W'($urandom);
    req.range_high = POS_W'($urandom);
    return req;
  endfunction

  function automatic segsum_req_t make_query(int unsigned lo, int unsigned hi);
    segsum_req_t req;
    req.opcode     = OP_QUERY;
    req.position   = POS_W'($urandom);
    req.new_value  = $urandom;
    req.range_low  = lo[POS_W-1:0];
    req.range_high = hi[POS_W-1:0];
    return req;
  endfunction

  // Present one transaction, hold it until accepted, then record its result
  task automatic send_request(segsum_req_t req);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data_i  = req;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall_o) break;
    end
    pending_sums.push_back(apply_request(req));
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
  endtask

  // Write the count register once the block is idle; it clears both stores
  task automatic write_element_count(logic [CNT_W-1:0] count);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data_i = count;
    cfg_we_i   = 1'b1;
    @(negedge clk);
    cfg_we_i   = 1'b0;
    position_count = (count > NUM_POSITIONS) ? NUM_POSITIONS : count;
    foreach (value_store[i]) value_store[i] = '0;
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall_i = rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    segsum_rsp_t exp_rsp;
    if (rst_n && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result sum=%0d bad=%0b", $time,
                 out_data_o.range_sum, out_data_o.bad_request);
      end else begin
        exp_rsp = pending_sums.pop_front();
        if (out_data_o.range_sum !== exp_rsp.range_sum) begin
          error_count++;
          $display("%0t: range_sum expected %0d actual %0d", $time,
                   exp_rsp.range_sum, out_data_o.range_sum);
        end
        if (out_data_o.bad_request !== exp_rsp.bad_request) begin
          error_count++;
          $display("%0t: bad_request expected %0b actual %0b", $time,
                   exp_rsp.bad_request, out_data_o.bad_request);
        end
      end
    end
  end

  // Extreme values at the ends of the full range, with wrapping sums
  task automatic test_value_extremes();
    send_request(make_set(0, 32'h7FFF_FFFF));
    send_request(make_set(NUM_POSITIONS - 1, 32'h8000_0000));
    send_request(make_set(512, 32'hFFFF_FFFF));
    send_request(make_query(0, NUM_POSITIONS - 1));
    send_request(make_query(0, 0));
    send_request(make_query(NUM_POSITIONS - 1, NUM_POSITIONS - 1));
    send_request(make_set(NUM_POSITIONS - 1, 32'h7FFF_FFFF));
    send_request(make_query(511, 512));
    send_request(make_query(NUM_POSITIONS - 2, NUM_POSITIONS - 1));
    send_request(make_query(0, NUM_POSITIONS - 1));
  endtask

  // Out-of-range sets and rejected queries
  task automatic test_bad_requests();
    send_request(make_query(5, 3));
    write_element_count(3);
    send_request(make_set(3, 32'h1234_5678));
    send_request(make_set(2, 32'hDEAD_BEEF));
    send_request(make_query(0, 2));
    send_request(make_query(0, 3));
    send_request(make_query(2, 2));
  endtask

  // Count of zero, one, and a count that saturates
  task automatic test_count_limits();
    write_element_count(0);
    send_request(make_set(0, 32'h0000_0001));
    send_request(make_query(0, 0));
    write_element_count('1);
    send_request(make_query(0, NUM_POSITIONS - 1));
    send_request(make_set(NUM_POSITIONS - 1, 32'h0000_0005));
    send_request(make_query(NUM_POSITIONS - 1, NUM_POSITIONS - 1));
    write_element_count(1);
    send_request(make_set(0, 32'h8000_0000));
    send_request(make_set(1, 32'h0000_0007));
    send_request(make_query(0, 0));
    send_request(make_query(0, 1));
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return CNT_W'(NUM_POSITIONS);
      1: return CNT_W'($urandom_range(1, 8));
      2: return CNT_W'($urandom_range(9, 64));
      3: return CNT_W'($urandom_range(65, NUM_POSITIONS - 1));
      4: return CNT_W'($urandom_range(NUM_POSITIONS + 1, 2047));
      default: return CNT_W'($urandom_range(2, 16));
    endcase
  endfunction

  // Mostly in-bounds sets and queries, some noise, under one idle pattern
  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct);
    int unsigned lo;
    int unsigned hi;
    bit          in_bounds;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      write_element_count(pick_count());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 49) == 0) wait_for_results();
        in_bounds = (position_count != 0) && ($urandom_range(0, 9) < 8);
        if ($urandom_range(0, 1) == 0) begin
          lo = in_bounds ? $urandom_range(0, position_count - 1)
                         : $urandom_range(0, NUM_POSITIONS - 1);
          send_request(make_set(lo, pick_value()));
        end else begin
          if (in_bounds) begin
            lo = $urandom_range(0, position_count - 1);
            hi = $urandom_range(lo, position_count - 1);
          end else begin
            lo = $urandom_range(0, NUM_POSITIONS - 1);
            hi = $urandom_range(0, NUM_POSITIONS - 1);
          end
          send_request(make_query(lo, hi));
        end
      end
    end
  endtask

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n         = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    position_count = NUM_POSITIONS;
    foreach (value_store[i]) value_store[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_value_extremes();
    test_bad_requests();
    test_count_limits();
    test_random_traffic(34, 57);
    test_random_traffic(57, 34);
    test_random_traffic(0, 0);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
